>>> rtl/core/psfm_pkg.sv
package psfm_pkg;

	// Field widths
	localparam int SPEED_W = 10;
	localparam int FLOW_W = 7;
	localparam int TICKS_W = 8;
	localparam int LEVEL_W = 2;
	localparam int CFG_IDX_W = 4;
	localparam int CFG_DATA_W = 10;

	// Default persistence counter width
	localparam int COUNTER_WIDTH_DEF = 9;

	// Speed band edges (rpm) and matching flow limits (l/h)
	localparam logic [SPEED_W-1:0] BAND_SPEED_1 = 10'd200;
	localparam logic [SPEED_W-1:0] BAND_SPEED_2 = 10'd400;
	localparam logic [SPEED_W-1:0] BAND_SPEED_3 = 10'd600;
	localparam logic [FLOW_W-1:0] BAND_FLOW_1 = 7'd20;
	localparam logic [FLOW_W-1:0] BAND_FLOW_2 = 7'd50;
	localparam logic [FLOW_W-1:0] BAND_FLOW_3 = 7'd75;
	localparam logic [FLOW_W-1:0] BAND_FLOW_TOP = 7'd80;

	// Overspeed level
	typedef enum logic [LEVEL_W-1:0] {
		LVL_NONE = 2'd0,
		LVL_WARN = 2'd1,
		LVL_CRIT = 2'd2
	} level_t;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SPEED_LIMIT_ONE = 4'd0,
		CFG_SPEED_LIMIT_TWO = 4'd1,
		CFG_RESOLVE_ONE_SPEED = 4'd2,
		CFG_RESOLVE_TWO_SPEED = 4'd3,
		CFG_WARN_ONE_TICKS = 4'd4,
		CFG_WARN_TWO_TICKS = 4'd5,
		CFG_RESOLVE_TICKS = 4'd6,
		CFG_RELATION_TICKS = 4'd7
	} cfg_idx_t;

	// Configuration register file contents
	typedef struct packed {
		logic [SPEED_W-1:0] speed_limit_one;
		logic [SPEED_W-1:0] speed_limit_two;
		logic [SPEED_W-1:0] resolve_one_speed;
		logic [SPEED_W-1:0] resolve_two_speed;
		logic [TICKS_W-1:0] warn_one_ticks;
		logic [TICKS_W-1:0] warn_two_ticks;
		logic [TICKS_W-1:0] resolve_ticks;
		logic [TICKS_W-1:0] relation_ticks;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		speed_limit_one: 10'd700,
		speed_limit_two: 10'd900,
		resolve_one_speed: 10'd650,
		resolve_two_speed: 10'd800,
		warn_one_ticks: 8'd100,
		warn_two_ticks: 8'd60,
		resolve_ticks: 8'd60,
		relation_ticks: 8'd60
	};

endpackage

>>> rtl/core/psfm_sample_if.sv
interface psfm_sample_if;
	logic valid;
	logic ready;
	logic [psfm_pkg::SPEED_W-1:0] motor_speed;
	logic [psfm_pkg::FLOW_W-1:0] flow_rate;

	modport source (output valid, output motor_speed, output flow_rate, input ready);
	modport sink (input valid, input motor_speed, input flow_rate, output ready);
endinterface

>>> rtl/core/psfm_result_if.sv
interface psfm_result_if;
	logic valid;
	logic ready;
	logic [psfm_pkg::LEVEL_W-1:0] speed_level;
	logic relation_violation;
	logic [psfm_pkg::LEVEL_W-1:0] worst_level;

	modport source (output valid, output speed_level, output relation_violation,
		output worst_level, input ready);
	modport sink (input valid, input speed_level, input relation_violation,
		input worst_level, output ready);
endinterface

>>> rtl/core/psfm_cfg_if.sv
interface psfm_cfg_if;
	logic valid;
	logic ready;
	logic [psfm_pkg::CFG_IDX_W-1:0] index;
	logic [psfm_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/core/psfm_cfg_regs.sv
module psfm_cfg_regs (
	input  logic clk,
	input  logic arst_n,
	psfm_cfg_if.sink cfg,
	output psfm_pkg::cfg_t regs
);

	psfm_pkg::cfg_t regs_q;

	// Writes are always taken; unknown indexes are dropped
	assign cfg.ready = 1'b1;
	assign regs = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= psfm_pkg::CFG_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				psfm_pkg::CFG_SPEED_LIMIT_ONE: begin
					regs_q.speed_limit_one <= cfg.data;
				end
				psfm_pkg::CFG_SPEED_LIMIT_TWO: begin
					regs_q.speed_limit_two <= cfg.data;
				end
				psfm_pkg::CFG_RESOLVE_ONE_SPEED: begin
					regs_q.resolve_one_speed <= cfg.data;
				end
				psfm_pkg::CFG_RESOLVE_TWO_SPEED: begin
					regs_q.resolve_two_speed <= cfg.data;
				end
				psfm_pkg::CFG_WARN_ONE_TICKS: begin
					regs_q.warn_one_ticks <= cfg.data[psfm_pkg::TICKS_W-1:0];
				end
				psfm_pkg::CFG_WARN_TWO_TICKS: begin
					regs_q.warn_two_ticks <= cfg.data[psfm_pkg::TICKS_W-1:0];
				end
				psfm_pkg::CFG_RESOLVE_TICKS: begin
					regs_q.resolve_ticks <= cfg.data[psfm_pkg::TICKS_W-1:0];
				end
				psfm_pkg::CFG_RELATION_TICKS: begin
					regs_q.relation_ticks <= cfg.data[psfm_pkg::TICKS_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

endmodule

>>> rtl/core/psfm_speed_track.sv
module psfm_speed_track #(
	parameter int COUNTER_WIDTH = psfm_pkg::COUNTER_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic [psfm_pkg::SPEED_W-1:0] speed,
	input  psfm_pkg::cfg_t cfg,
	output psfm_pkg::level_t level_nxt
);

	localparam logic [COUNTER_WIDTH-1:0] CNT_MAX = '1;

	logic [COUNTER_WIDTH-1:0] above_one_q, above_two_q, below_one_q, below_two_q;
	logic [COUNTER_WIDTH-1:0] above_one_nxt, above_two_nxt, below_one_nxt, below_two_nxt;
	logic [COUNTER_WIDTH-1:0] above_one_inc, above_two_inc, below_one_inc, below_two_inc;
	logic [COUNTER_WIDTH-1:0] warn_one_ext, warn_two_ext, resolve_ext;
	psfm_pkg::level_t level_q;
	psfm_pkg::level_t lvl_a, lvl_b, lvl_c;

	// Saturating increments
	assign above_one_inc = (above_one_q == CNT_MAX) ? above_one_q : above_one_q + 1'b1;
	assign above_two_inc = (above_two_q == CNT_MAX) ? above_two_q : above_two_q + 1'b1;
	assign below_one_inc = (below_one_q == CNT_MAX) ? below_one_q : below_one_q + 1'b1;
	assign below_two_inc = (below_two_q == CNT_MAX) ? below_two_q : below_two_q + 1'b1;

	assign warn_one_ext = COUNTER_WIDTH'(cfg.warn_one_ticks);
	assign warn_two_ext = COUNTER_WIDTH'(cfg.warn_two_ticks);
	assign resolve_ext = COUNTER_WIDTH'(cfg.resolve_ticks);

	// Persistence counters above the two limits
	always_comb begin
		if (speed > cfg.speed_limit_two) begin
			above_one_nxt = above_one_inc;
			above_two_nxt = above_two_inc;
		end else if (speed > cfg.speed_limit_one) begin
			above_one_nxt = above_one_inc;
			above_two_nxt = '0;
		end else begin
			above_one_nxt = '0;
			above_two_nxt = '0;
		end
	end

	// Resolve counters; below resolve one the resolve-two count holds
	always_comb begin
		if (speed < cfg.resolve_one_speed) begin
			below_one_nxt = below_one_inc;
			below_two_nxt = below_two_q;
		end else if (speed < cfg.resolve_two_speed) begin
			below_one_nxt = '0;
			below_two_nxt = below_two_inc;
		end else begin
			below_one_nxt = '0;
			below_two_nxt = '0;
		end
	end

	// Level rules, applied in order
	always_comb begin
		lvl_a = level_q;
		if (above_one_nxt > warn_one_ext && level_q == psfm_pkg::LVL_NONE) begin
			lvl_a = psfm_pkg::LVL_WARN;
		end
		lvl_b = lvl_a;
		if (above_two_nxt > warn_two_ext) begin
			lvl_b = psfm_pkg::LVL_CRIT;
		end
		lvl_c = lvl_b;
		if (below_two_nxt > resolve_ext && lvl_b == psfm_pkg::LVL_CRIT) begin
			lvl_c = psfm_pkg::LVL_WARN;
		end
		level_nxt = lvl_c;
		if (below_one_nxt > resolve_ext && lvl_c == psfm_pkg::LVL_WARN) begin
			level_nxt = psfm_pkg::LVL_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			above_one_q <= '0;
			above_two_q <= '0;
			below_one_q <= '0;
			below_two_q <= '0;
			level_q <= psfm_pkg::LVL_NONE;
		end else if (en) begin
			above_one_q <= above_one_nxt;
			above_two_q <= above_two_nxt;
			below_one_q <= below_one_nxt;
			below_two_q <= below_two_nxt;
			level_q <= level_nxt;
		end
	end

endmodule

>>> rtl/core/psfm_relation.sv
module psfm_relation #(
	parameter int COUNTER_WIDTH = psfm_pkg::COUNTER_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic [psfm_pkg::SPEED_W-1:0] speed,
	input  logic [psfm_pkg::FLOW_W-1:0] flow,
	input  logic [psfm_pkg::TICKS_W-1:0] relation_ticks,
	output logic viol_nxt
);

	localparam logic [COUNTER_WIDTH-1:0] CNT_MAX = '1;

	logic [COUNTER_WIDTH-1:0] mismatch_q, mismatch_nxt;
	logic fits;

	// Flow band required by the speed band
	always_comb begin
		if (speed <= psfm_pkg::BAND_SPEED_1) begin
			fits = (flow != '0) && (flow <= psfm_pkg::BAND_FLOW_1);
		end else if (speed <= psfm_pkg::BAND_SPEED_2) begin
			fits = (flow > psfm_pkg::BAND_FLOW_1) && (flow <= psfm_pkg::BAND_FLOW_2);
		end else if (speed <= psfm_pkg::BAND_SPEED_3) begin
			fits = (flow > psfm_pkg::BAND_FLOW_2) && (flow <= psfm_pkg::BAND_FLOW_3);
		end else begin
			fits = (flow <= psfm_pkg::BAND_FLOW_TOP);
		end
	end

	// Zero speed or a match clears; a mismatch counts up and saturates
	always_comb begin
		if (speed == '0 || fits) begin
			mismatch_nxt = '0;
		end else if (mismatch_q == CNT_MAX) begin
			mismatch_nxt = mismatch_q;
		end else begin
			mismatch_nxt = mismatch_q + 1'b1;
		end
	end

	assign viol_nxt = (mismatch_nxt >= COUNTER_WIDTH'(relation_ticks));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mismatch_q <= '0;
		end else if (en) begin
			mismatch_q <= mismatch_nxt;
		end
	end

endmodule

>>> rtl/core/pump_speed_flow_monitor.sv
// Pump speed and flow monitor.
// samp (sink): one word per sample tick, motor_speed (rpm) and flow_rate (l/h).
// res (source): one word per sample: speed_level (0 none, 1 warning,
//   2 critical), relation_violation, and worst_level, the larger of the two.
// cfg (sink): register writes by index, always ready; index 0..7 selects
//   speed_limit_one, speed_limit_two, resolve_one_speed, resolve_two_speed,
//   warn_one_ticks, warn_two_ticks, resolve_ticks, relation_ticks.
//   Indexes above 7 are dropped. Write only while no sample is in flight.
// Path: a taken word sits in the input register and moves on into the
//   result register once that is free; its result is then valid on res.
// Throughput: one word per cycle unless res stalls. The input register
//   feeds the counter update and the result register through a single level
//   of logic; samp stays ready while the result register drains or is empty.
// Stall: when res is not taken, the result holds, the input register fills,
//   and samp.ready drops until res moves again. Counters advance only when a
//   word moves into the result register.
// Reset (arst_n low): counters and level clear, registers take their
//   defaults, both pipeline stages empty.
module pump_speed_flow_monitor #(
	parameter int COUNTER_WIDTH = psfm_pkg::COUNTER_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	psfm_sample_if.sink samp,
	psfm_result_if.source res,
	psfm_cfg_if.sink cfg
);

	psfm_pkg::cfg_t regs;
	logic valid_s1, valid_s2;
	logic [psfm_pkg::SPEED_W-1:0] speed_s1;
	logic [psfm_pkg::FLOW_W-1:0] flow_s1;
	logic adv;
	psfm_pkg::level_t level_nxt;
	psfm_pkg::level_t level_s2;
	logic viol_nxt, viol_s2;
	logic [psfm_pkg::LEVEL_W-1:0] worst_nxt, worst_s2;

	psfm_cfg_regs u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.regs(regs)
	);

	// Handshake: stage 1 moves when the result register is free
	assign adv = valid_s1 && (!valid_s2 || res.ready);
	assign samp.ready = !valid_s1 || adv;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (samp.ready) begin
			valid_s1 <= samp.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (samp.valid && samp.ready) begin
			speed_s1 <= samp.motor_speed;
			flow_s1 <= samp.flow_rate;
		end
	end

	psfm_speed_track #(.COUNTER_WIDTH(COUNTER_WIDTH)) u_speed (
		.clk(clk),
		.arst_n(arst_n),
		.en(adv),
		.speed(speed_s1),
		.cfg(regs),
		.level_nxt(level_nxt)
	);

	psfm_relation #(.COUNTER_WIDTH(COUNTER_WIDTH)) u_rel (
		.clk(clk),
		.arst_n(arst_n),
		.en(adv),
		.speed(speed_s1),
		.flow(flow_s1),
		.relation_ticks(regs.relation_ticks),
		.viol_nxt(viol_nxt)
	);

	// Worst of level and violation flag
	assign worst_nxt = (viol_nxt && level_nxt == psfm_pkg::LVL_NONE) ?
		psfm_pkg::LVL_WARN : level_nxt;

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (res.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			level_s2 <= level_nxt;
			viol_s2 <= viol_nxt;
			worst_s2 <= worst_nxt;
		end
	end

	assign res.valid = valid_s2;
	assign res.speed_level = level_s2;
	assign res.relation_violation = viol_s2;
	assign res.worst_level = worst_s2;

	// A taken sample always lands in the input register
	a_take_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		samp.valid && samp.ready |=> valid_s1)
		else $error("accepted sample not held in input register");

	// With no overspeed, the worst level follows the violation flag
	a_worst_flag: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.speed_level == psfm_pkg::LVL_NONE |->
		res.worst_level == {1'b0, res.relation_violation})
		else $error("worst level does not follow violation flag");

	// A zero relation threshold flags every result
	a_zero_ticks: assert property (@(posedge clk) disable iff (!arst_n)
		adv && regs.relation_ticks == '0 |=> res.relation_violation)
		else $error("violation not flagged with zero threshold");

	// A stalled result keeps the input side from taking a second word
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && valid_s2 && !res.ready |-> !samp.ready)
		else $error("input taken while both stages are full and stalled");

endmodule
